// File: sv/slm_pkg.sv
// Shared types and constants for the subwoofer low-pass mix block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package slm_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int MAX_CHANNELS = 8;

    // rounding shift from the Q8.40 delay format back to sample width
    localparam int OUT_SHIFT = 41 - SAMPLE_BITS;

    // shared multiplier operands: coefficient or mixed sample, and delay or gain slice
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sequencer: two gain products, then 16 products over the two sections
    localparam int STEP_W     = 5;
    localparam int LAST_ISSUE = 17;
    localparam int LAST_STEP  = LAST_ISSUE + 1;

    typedef enum logic [2:0] {
        CFG_SEC1_FB     = 3'd0,
        CFG_SEC1_FF     = 3'd1,
        CFG_SEC2_FB     = 3'd2,
        CFG_SEC2_FF     = 3'd3,
        CFG_INPUT_GAIN  = 3'd4,
        CFG_SUB_CHANNEL = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sub_sample;
        logic [2:0]                    channel_slot;
    } t_out;

    typedef struct packed {
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              load_in;
        logic              finish;
    } t_ctrl;

    // keep the low COEF_BITS of a coefficient word, left-aligned in Q2.30
    function automatic logic signed [31:0] coef_align(input logic [31:0] word);
        coef_align = signed'(word << (32 - COEF_BITS));
    endfunction

endpackage
`default_nettype wire

// File: sv/subwoofer_lowpass_mix_top.sv
// Top level of the subwoofer low-pass mix: config registers, operand select,
// accumulator, delay line and output register. Depends on slm_pkg, slm_mul, slm_ctrl.
//
//   channel | direction | handshake                  | payload
//   in      | request   | i_in_valid / o_in_ready    | i_in_data   (slm_pkg::t_in)
//   out     | result    | o_out_valid / i_out_ready  | o_out_data  (slm_pkg::t_out)
//   cfg     | write     | i_cfg_we                   | i_cfg_addr, i_cfg_wdata
//
// Requests are taken one at a time, and only in the idle state: 18 products
// go one per cycle through the single 33x25 multiplier, followed by a drain
// step, the finish step and the idle state. Synchronous active-low reset clears
// config, delays and control. A stalled output holds the finish step until the
// output register frees; the next request is accepted while a result still waits.
`default_nettype none
module subwoofer_lowpass_mix_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire slm_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output slm_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [63:0]   i_cfg_wdata
);

    localparam int ACC_W = 52;
    localparam int PART_W = slm_pkg::PROD_W - 24;

    // configuration
    logic [63:0] r_sec1_fb, r_sec1_ff, r_sec2_fb, r_sec2_ff;
    logic [47:0] r_gain;
    logic [2:0]  r_sub_channel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec1_fb     <= '0;
            r_sec1_ff     <= '0;
            r_sec2_fb     <= '0;
            r_sec2_ff     <= '0;
            r_gain        <= '0;
            r_sub_channel <= 3'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                slm_pkg::CFG_SEC1_FB:     r_sec1_fb     <= i_cfg_wdata;
                slm_pkg::CFG_SEC1_FF:     r_sec1_ff     <= i_cfg_wdata;
                slm_pkg::CFG_SEC2_FB:     r_sec2_fb     <= i_cfg_wdata;
                slm_pkg::CFG_SEC2_FF:     r_sec2_ff     <= i_cfg_wdata;
                slm_pkg::CFG_INPUT_GAIN:  r_gain        <= i_cfg_wdata[47:0];
                slm_pkg::CFG_SUB_CHANNEL: r_sub_channel <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // sequencer
    slm_pkg::t_ctrl w_ctrl;
    logic           w_out_free;
    logic           r_out_vld;
    slm_pkg::t_out  r_out_data;

    assign w_out_free = !r_out_vld || i_out_ready;

    slm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    // mixed sample: floor((l + r) / 2) taken as Q1.31
    logic signed [31:0] r_x;
    logic signed [slm_pkg::SAMPLE_BITS:0] w_lr;

    assign w_lr = {i_in_data.left_sample[slm_pkg::SAMPLE_BITS-1], i_in_data.left_sample}
                + {i_in_data.right_sample[slm_pkg::SAMPLE_BITS-1], i_in_data.right_sample};

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_in) begin
            r_x <= {w_lr[slm_pkg::SAMPLE_BITS:1], {(32 - slm_pkg::SAMPLE_BITS){1'b0}}};
        end
    end

    // delay line: index {section, age}
    logic signed [47:0] r_dly [4];

    // operand select for the issuing step
    logic [slm_pkg::STEP_W-1:0]          w_it;
    logic                                w_i_gain, w_i_sec, w_i_ff, w_i_half;
    logic [63:0]                         w_coef_reg;
    logic [31:0]                         w_coef_word;
    logic signed [47:0]                  w_h;
    logic signed [slm_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [slm_pkg::MUL_B_W-1:0]  w_mul_b;

    assign w_it     = w_ctrl.step - slm_pkg::STEP_W'(2);
    assign w_i_gain = (w_ctrl.step < slm_pkg::STEP_W'(2));
    assign w_i_sec  = w_it[3];
    assign w_i_ff   = w_it[2];
    assign w_i_half = w_it[1];

    always_comb begin
        unique case ({w_i_sec, w_i_ff})
            2'b00:   w_coef_reg = r_sec1_fb;
            2'b01:   w_coef_reg = r_sec1_ff;
            2'b10:   w_coef_reg = r_sec2_fb;
            default: w_coef_reg = r_sec2_ff;
        endcase
        w_coef_word = w_i_half ? w_coef_reg[63:32] : w_coef_reg[31:0];
        w_h = r_dly[{w_i_sec, w_i_half}];
        if (w_i_gain) begin
            w_mul_a = {r_x[31], r_x};
            w_mul_b = w_ctrl.step[0] ? {1'b0, r_gain[47:24]} : {1'b0, r_gain[23:0]};
        end else begin
            w_mul_a = slm_pkg::MUL_A_W'(slm_pkg::coef_align(w_coef_word));
            w_mul_b = w_ctrl.step[0] ? {w_h[47], w_h[47:24]} : {1'b0, w_h[23:0]};
        end
    end

    logic signed [slm_pkg::PROD_W-1:0] w_prod;
    logic [slm_pkg::STEP_W-1:0]        w_pstep;
    logic                              w_pvld;

    slm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ctrl.issue),
        .i_step  (w_ctrl.step),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_step  (w_pstep),
        .o_vld   (w_pvld)
    );

    // accumulate stage: a low product leaves floor(p / 2^24); the matching
    // high product completes floor(full product / 2^shift)
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:47] == '0 || v[ACC_W-1:47] == '1) begin
            sat48 = v;
        end else if (v[ACC_W-1]) begin
            sat48 = {{(ACC_W-47){1'b1}}, 47'd0};
        end else begin
            sat48 = {{(ACC_W-47){1'b0}}, {47{1'b1}}};
        end
    endfunction

    logic signed [PART_W-1:0]          r_part;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [47:0]                r_hn;
    logic signed [slm_pkg::PROD_W-1:0] w_full;
    logic signed [ACC_W-1:0]           w_term, w_u, w_sum, w_sat;
    logic [slm_pkg::STEP_W-1:0]        w_pt;
    logic                              w_p_gain, w_p_sec, w_p_ff, w_p_half;

    assign w_full   = w_prod + {{(slm_pkg::PROD_W - PART_W){r_part[PART_W-1]}}, r_part};
    assign w_term   = w_full[slm_pkg::PROD_W-1:6];
    assign w_u      = ACC_W'($signed(w_full[slm_pkg::PROD_W-1:15]));
    assign w_pt     = w_pstep - slm_pkg::STEP_W'(2);
    assign w_p_gain = (w_pstep < slm_pkg::STEP_W'(2));
    assign w_p_sec  = w_pt[3];
    assign w_p_ff   = w_pt[2];
    assign w_p_half = w_pt[1];
    assign w_sum    = w_p_ff ? r_acc + w_term : r_acc - w_term;
    assign w_sat    = sat48(w_sum);

    always_ff @(posedge i_clk) begin
        if (w_pvld) begin
            if (!w_pstep[0]) begin
                r_part <= w_prod[slm_pkg::PROD_W-1:24];
            end else if (w_p_gain) begin
                r_acc <= w_u;
            end else if (!w_p_half) begin
                r_acc <= w_sum;
            end else begin
                r_acc <= w_sat;
                if (!w_p_ff) begin
                    r_hn <= w_sat[47:0];
                end
            end
        end
    end

    // commit the section's delays once its output is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_dly[i] <= '0;
            end
        end else if (w_pvld && w_pstep[0] && !w_p_gain && w_p_ff && w_p_half) begin
            r_dly[{w_p_sec, 1'b1}] <= r_dly[{w_p_sec, 1'b0}];
            r_dly[{w_p_sec, 1'b0}] <= r_hn;
        end
    end

    // round half up to sample width, then saturate
    localparam int Q_W = 49 - slm_pkg::OUT_SHIFT;
    logic signed [48:0]   w_rnd;
    logic signed [Q_W-1:0] w_q;
    logic signed [slm_pkg::SAMPLE_BITS-1:0] w_sub;
    logic [2:0] w_slot;

    assign w_rnd = {r_acc[47], r_acc[47:0]} + (49'sd1 <<< (slm_pkg::OUT_SHIFT - 1));
    assign w_q   = w_rnd[48:slm_pkg::OUT_SHIFT];

    always_comb begin
        if (w_q > Q_W'((64'sd1 <<< (slm_pkg::SAMPLE_BITS - 1)) - 64'sd1)) begin
            w_sub = {1'b0, {(slm_pkg::SAMPLE_BITS-1){1'b1}}};
        end else if (w_q < -Q_W'(64'sd1 <<< (slm_pkg::SAMPLE_BITS - 1))) begin
            w_sub = {1'b1, {(slm_pkg::SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sub = w_q[slm_pkg::SAMPLE_BITS-1:0];
        end
        if ({1'b0, r_sub_channel} >= 4'(slm_pkg::MAX_CHANNELS)) begin
            w_slot = 3'(slm_pkg::MAX_CHANNELS - 1);
        end else begin
            w_slot = r_sub_channel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctrl.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_out_data.sub_sample   <= w_sub;
            r_out_data.channel_slot <= w_slot;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: sv/slm_mul.sv
// Shared signed multiplier with registered product and step tag.
// Depends on slm_pkg.
`default_nettype none
module slm_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic [slm_pkg::STEP_W-1:0]           i_step,
    input  wire logic signed [slm_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [slm_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [slm_pkg::PROD_W-1:0]         o_prod,
    output logic [slm_pkg::STEP_W-1:0]                o_step,
    output logic                                      o_vld
);

    logic signed [slm_pkg::PROD_W-1:0] r_prod;
    logic [slm_pkg::STEP_W-1:0]        r_step;
    logic                              r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_step <= i_step;
        end
    end

    assign o_prod = r_prod;
    assign o_step = r_step;
    assign o_vld  = r_vld;

endmodule
`default_nettype wire

// File: sv/slm_ctrl.sv
// Sequencer: accepts a request, steps the shared multiplier, hands off the result.
// Depends on slm_pkg.
`default_nettype none
module slm_ctrl (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_out_free,
    output logic        o_in_ready,
    output slm_pkg::t_ctrl o_ctrl
);

    slm_pkg::t_state r_state, n_state;
    logic [slm_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slm_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            slm_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = slm_pkg::ST_RUN;
                end
            end
            slm_pkg::ST_RUN: begin
                if (r_step == slm_pkg::STEP_W'(slm_pkg::LAST_STEP)) begin
                    n_state = slm_pkg::ST_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            slm_pkg::ST_FIN: begin
                if (i_out_free) begin
                    n_state = slm_pkg::ST_IDLE;
                end
            end
            default: n_state = slm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctrl.issue   = 1'b0;
        o_ctrl.step    = r_step;
        o_ctrl.load_in = 1'b0;
        o_ctrl.finish  = 1'b0;
        unique case (r_state)
            slm_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.load_in = i_in_valid;
            end
            slm_pkg::ST_RUN: begin
                o_ctrl.issue = (r_step <= slm_pkg::STEP_W'(slm_pkg::LAST_ISSUE));
            end
            slm_pkg::ST_FIN: begin
                o_ctrl.finish = i_out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/slm_chk.sv
// Port-level checker for the subwoofer low-pass mix, bound to the top level.
// Depends on slm_pkg and subwoofer_lowpass_mix_top.
`default_nettype none
module slm_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire slm_pkg::t_out o_out_data
);

    // one request at a time: the block goes busy right after accepting
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted request");

    // a result only appears from the finish step, never straight from idle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while block was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    a_out_clear_on_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind subwoofer_lowpass_mix_top slm_chk u_chk (.*);
`default_nettype wire
